// ===== rtl/core/lku_pkg.sv =====
// lku_pkg: constants, tables and byte-level functions for the license key unwrap core.
// AES-128 inverse cipher helpers, fixed round keys, mixing tables.
// No dependencies.
package lku_pkg;

  localparam int unsigned MixRounds = 5;
  localparam int unsigned AesRounds = 10;
  // one pipeline stage for the input key add, one per AES round and one per mixing round
  localparam int unsigned Depth = AesRounds + 1 + MixRounds;
  localparam int unsigned RoundW = $clog2(AesRounds + 1);

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;  // index = byte number
  typedef byte_t [255:0] sbox_t;

  localparam logic [127:0] FixedKey = 128'h869F7745C13FD890CCF29188E3CC3EDF;

  function automatic logic [3:0] perm_order(input int unsigned i);
    logic [127:0] w;
    w = {8'h0C, 8'h03, 8'h06, 8'h04, 8'h01, 8'h0B, 8'h0F, 8'h08,
         8'h02, 8'h07, 8'h00, 8'h05, 8'h0A, 8'h0E, 8'h0D, 8'h09};
    return w[123 - 8*i -: 4];
  endfunction

  function automatic byte_t xor_mask(input int unsigned i);
    logic [127:0] w;
    w = 128'hA93E1FD67C55A329B75FDDA62A95C7A5;
    return w[127 - 8*i -: 8];
  endfunction

  function automatic byte_t sub_table(input int unsigned i);
    logic [127:0] w;
    w = 128'h67D45DA3296D006A4E7C537BF5538C74;
    return w[127 - 8*i -: 8];
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t r, x;
    r = '0;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r ^= x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic byte_t fwd_sbox(input byte_t x);
    byte_t inv, base, s;
    logic [7:0] e;
    inv = 8'h01;
    base = x;
    e = 8'd254;
    for (int k = 0; k < 8; k++) begin
      if (e[k]) inv = gf_mul(inv, base);
      base = gf_mul(base, base);
    end
    if (x == 8'h00) inv = 8'h00;
    s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    return s;
  endfunction

  // constant table, elaborated once
  function automatic sbox_t build_inv_sbox();
    sbox_t t;
    t = '0;
    for (int v = 0; v < 256; v++) t[fwd_sbox(byte_t'(v))] = byte_t'(v);
    return t;
  endfunction

  localparam sbox_t InvSbox = build_inv_sbox();

  function automatic byte_t inv_sbox(input byte_t y);
    return InvSbox[y];
  endfunction

  // constant table, elaborated once
  function automatic state_t [AesRounds:0] build_round_keys();
    state_t [AesRounds:0] rk;
    byte_t rcon;
    byte_t t0, t1, t2, t3, f;
    logic [7:0] w [0:175];
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) w[i] = FixedKey[127 - 8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      t0 = w[i-4]; t1 = w[i-3]; t2 = w[i-2]; t3 = w[i-1];
      if ((i % 16) == 0) begin
        f = t0;
        t0 = fwd_sbox(t1) ^ rcon;
        t1 = fwd_sbox(t2);
        t2 = fwd_sbox(t3);
        t3 = fwd_sbox(f);
        rcon = xtime(rcon);
      end
      w[i] = w[i-16] ^ t0; w[i+1] = w[i-15] ^ t1;
      w[i+2] = w[i-14] ^ t2; w[i+3] = w[i-13] ^ t3;
    end
    for (int r = 0; r <= AesRounds; r++)
      for (int i = 0; i < 16; i++) rk[r][i] = w[16*r + i];
    return rk;
  endfunction

  localparam state_t [AesRounds:0] RoundKeys = build_round_keys();

  function automatic state_t add_key(input state_t s, input int unsigned r);
    state_t o;
    for (int i = 0; i < 16; i++) o[i] = s[i] ^ RoundKeys[r][i];
    return o;
  endfunction

  function automatic state_t inv_shift_sub(input state_t s);
    state_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = inv_sbox(s[r + 4*((c + 4 - r) % 4)]);
    return t;
  endfunction

  function automatic state_t inv_mix(input state_t s);
    state_t o;
    byte_t a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      o[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
      o[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
      o[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
      o[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
    end
    return o;
  endfunction

  // one mixing round; the borrow chain is a 128-bit subtract in perm order
  function automatic state_t mix_round(input state_t s);
    state_t m, x;
    logic [127:0] a, b, d;
    for (int i = 0; i < 16; i++) m[i] = s[i] ^ xor_mask(i);
    x = m;
    for (int i = 1; i < 16; i++) x[perm_order(i)] = m[perm_order(i)] ^ m[perm_order(i-1)];
    for (int i = 0; i < 16; i++) begin
      a[8*i +: 8] = x[perm_order(i)];
      b[8*i +: 8] = sub_table(perm_order(i));
    end
    d = a - b;
    for (int i = 0; i < 16; i++) x[perm_order(i)] = d[8*i +: 8];
    return x;
  endfunction

endpackage

// ===== rtl/core/lku_aes_stage.sv =====
// lku_aes_stage: one registered AES inverse round.
// Depends on lku_pkg.
module lku_aes_stage import lku_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [RoundW-1:0] round_i,
  input  logic              valid_i,
  input  state_t            data_i,
  output logic              valid_o,
  output state_t            data_o
);
  logic   valid_q;
  state_t data_q, data_d;

  always_comb begin
    data_d = inv_shift_sub(data_i);
    data_d = add_key(data_d, 32'(round_i));
    if (round_i != '0) data_d = inv_mix(data_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== rtl/core/lku_mix_stage.sv =====
// lku_mix_stage: one registered mixing round (mask, chain xor, borrow subtract).
// Depends on lku_pkg.
module lku_mix_stage import lku_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  state_t data_i,
  output logic   valid_o,
  output state_t data_o
);
  logic   valid_q;
  state_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= mix_round(data_i);
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== rtl/core/license_key_unwrap_core.sv =====
// license_key_unwrap_core: AES-128 decrypt under fixed key, then mixing rounds.
// Pipeline from start to done_o: input key add, 10 AES rounds, 5 mix rounds, each a registered stage.
// Throughput: one block per cycle; busy is tied low, each stage is one round.
// Reset: asynchronous active low clears all stage valid bits; no clearing pass.
// Results cannot be stalled: done_o pulses for one cycle per accepted beat.
module license_key_unwrap_core import lku_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        done_o,
  output logic [63:0] key_high_o,
  output logic [63:0] key_low_o
);
  localparam int unsigned Stages = AesRounds + MixRounds;

  logic   valid_q;
  state_t data_q, in_s;
  logic   [Stages:0] v;
  state_t [Stages:0] d;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_s[i]     = block_high_i[63 - 8*i -: 8];
      in_s[8 + i] = block_low_i[63 - 8*i -: 8];
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= add_key(in_s, AesRounds);
  end

  assign v[0] = valid_q;
  assign d[0] = data_q;

  for (genvar g = 0; g < AesRounds; g++) begin : g_aes
    lku_aes_stage u_aes (
      .clk_i, .rst_ni,
      .round_i(RoundW'(AesRounds - 1 - g)),
      .valid_i(v[g]), .data_i(d[g]),
      .valid_o(v[g+1]), .data_o(d[g+1])
    );
  end

  for (genvar g = AesRounds; g < Stages; g++) begin : g_mix
    lku_mix_stage u_mix (
      .clk_i, .rst_ni,
      .valid_i(v[g]), .data_i(d[g]),
      .valid_o(v[g+1]), .data_o(d[g+1])
    );
  end

  assign done_o = v[Stages];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_high_o[63 - 8*i -: 8] = d[Stages][i];
      key_low_o[63 - 8*i -: 8]  = d[Stages][8 + i];
    end
  end
endmodule

// ===== rtl/core/lku_checker.sv =====
// lku_checker: port-level checks on the unwrap core.
// Depends on lku_pkg; bound to license_key_unwrap_core.
module lku_checker import lku_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);
  // every accepted beat yields a strobe after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Depth) done_o) else $error("missing result");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !$past(start && !busy, Depth)) |-> 1'b0) else $error("spurious result");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("core stalled");
endmodule

bind license_key_unwrap_core lku_checker u_lku_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o
);

// ===== verif/tb.sv =====
// tb: self-checking testbench for license_key_unwrap_core.
// Predicts each derived key with its own AES-128 inverse cipher and mixing rounds.
// Depends only on the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UnwrapLatency = 16;
  localparam int unsigned MixRoundCount = 5;

  localparam logic [7:0] FixedKeyBytes [16] = '{
    8'h86, 8'h9F, 8'h77, 8'h45, 8'hC1, 8'h3F, 8'hD8, 8'h90,
    8'hCC, 8'hF2, 8'h91, 8'h88, 8'hE3, 8'hCC, 8'h3E, 8'hDF};
  localparam logic [7:0] WalkOrder [16] = '{
    8'h0C, 8'h03, 8'h06, 8'h04, 8'h01, 8'h0B, 8'h0F, 8'h08,
    8'h02, 8'h07, 8'h00, 8'h05, 8'h0A, 8'h0E, 8'h0D, 8'h09};
  localparam logic [7:0] ByteMask [16] = '{
    8'hA9, 8'h3E, 8'h1F, 8'hD6, 8'h7C, 8'h55, 8'hA3, 8'h29,
    8'hB7, 8'h5F, 8'hDD, 8'hA6, 8'h2A, 8'h95, 8'hC7, 8'hA5};
  localparam logic [7:0] Subtrahend [16] = '{
    8'h67, 8'hD4, 8'h5D, 8'hA3, 8'h29, 8'h6D, 8'h00, 8'h6A,
    8'h4E, 8'h7C, 8'h53, 8'h7B, 8'hF5, 8'h53, 8'h8C, 8'h74};

  typedef struct {
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
    int unsigned idle_pct;
  } license_beat_t;

  typedef struct {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } derived_key_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        done_o;
  logic [63:0] key_high_o;
  logic [63:0] key_low_o;

  license_beat_t license_q[$];
  derived_key_t  expected_keys[$];
  int unsigned   mismatches = 0;

  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_inv [256];
  logic [7:0] sched [176];

  license_key_unwrap_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .block_high_i (block_high_i),
    .block_low_i  (block_low_i),
    .done_o       (done_o),
    .key_high_o   (key_high_o),
    .key_low_o    (key_low_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return r;
  endfunction

  task automatic build_cipher_tables();
    logic [7:0] inv, base, s, rcon, f;
    logic [7:0] t [4];
    logic [7:0] e;
    rcon = 8'h01;
    e = 8'd254;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      base = x[7:0];
      for (int k = 0; k < 8; k++) begin
        if (e[k]) inv = gf_times(inv, base);
        base = gf_times(base, base);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_fwd[x] = s;
      sbox_inv[s] = x[7:0];
    end
    for (int i = 0; i < 16; i++) sched[i] = FixedKeyBytes[i];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = sched[i-4+j];
      if ((i % 16) == 0) begin
        f = t[0];
        t[0] = sbox_fwd[t[1]] ^ rcon;
        t[1] = sbox_fwd[t[2]];
        t[2] = sbox_fwd[t[3]];
        t[3] = sbox_fwd[f];
        rcon = gf_times(rcon, 8'h02);
      end
      for (int j = 0; j < 4; j++) sched[i+j] = sched[i-16+j] ^ t[j];
    end
  endtask

  function automatic derived_key_t unwrap_key(logic [63:0] hi, logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    int diff, borrow;
    logic [3:0] p;
    derived_key_t k;
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63-8*i -: 8];
      s[8+i] = lo[63-8*i -: 8];
    end
    for (int rnd = 10; rnd >= 0; rnd--) begin
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r+4*c] = sbox_inv[s[r + 4*((c+4-r)%4)]];
        s = t;
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[16*rnd + i];
      if (rnd < 10 && rnd > 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_times(a0, 8'd14) ^ gf_times(a1, 8'd11) ^ gf_times(a2, 8'd13)
                     ^ gf_times(a3, 8'd9);
          s[4*c+1] = gf_times(a0, 8'd9) ^ gf_times(a1, 8'd14) ^ gf_times(a2, 8'd11)
                     ^ gf_times(a3, 8'd13);
          s[4*c+2] = gf_times(a0, 8'd13) ^ gf_times(a1, 8'd9) ^ gf_times(a2, 8'd14)
                     ^ gf_times(a3, 8'd11);
          s[4*c+3] = gf_times(a0, 8'd11) ^ gf_times(a1, 8'd13) ^ gf_times(a2, 8'd9)
                     ^ gf_times(a3, 8'd14);
        end
      end
    end
    for (int rnd = 0; rnd < MixRoundCount; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] ^= ByteMask[i];
      // walking down keeps the preceding byte at its old value
      for (int i = 15; i >= 1; i--) s[WalkOrder[i][3:0]] ^= s[WalkOrder[i-1][3:0]];
      borrow = 0;
      for (int i = 0; i < 16; i++) begin
        p = WalkOrder[i][3:0];
        diff = int'(s[p]) - int'(Subtrahend[p]) - borrow;
        borrow = (diff < 0) ? 1 : 0;
        s[p] = 8'((diff + 512) & 255);
      end
    end
    for (int i = 0; i < 8; i++) begin
      k.key_hi[63-8*i -: 8] = s[i];
      k.key_lo[63-8*i -: 8] = s[8+i];
    end
    return k;
  endfunction

  // driver: one beat per accept, optional idle cycles between beats
  always @(posedge clk_i) begin
    logic next_start;
    license_beat_t nb;
    next_start = start;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_keys = {expected_keys, unwrap_key(block_high_i, block_low_i)};
        next_start = 1'b0;
      end
      if (!next_start && license_q.size() > 0) begin
        if ($urandom_range(99) >= license_q[0].idle_pct) begin
          nb = license_q.pop_front();
          block_high_i <= nb.blk_hi;
          block_low_i <= nb.blk_lo;
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // monitor: done_o beats cannot be held off
  always @(posedge clk_i) begin
    derived_key_t exp_k;
    if (rst_ni && done_o) begin
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected key beat: %h %h", key_high_o, key_low_o);
      end else begin
        exp_k = expected_keys.pop_front();
        if (key_high_o !== exp_k.key_hi || key_low_o !== exp_k.key_lo) begin
          mismatches++;
          if (mismatches <= 10)
            $display("key mismatch: exp %h %h got %h %h",
                     exp_k.key_hi, exp_k.key_lo, key_high_o, key_low_o);
        end
      end
    end
  end

  task automatic add_beat(logic [63:0] hi, logic [63:0] lo, int unsigned idle);
    license_beat_t b;
    b.blk_hi = hi;
    b.blk_lo = lo;
    b.idle_pct = idle;
    license_q = {license_q, b};
  endtask

  initial begin
    int unsigned idle;
    build_cipher_tables();
    add_beat('0, '0, 0);
    add_beat('1, '1, 0);
    add_beat('0, '1, 0);
    add_beat('1, '0, 0);
    add_beat({8{8'hAA}}, {8{8'h55}}, 0);
    add_beat({8{8'h55}}, {8{8'hAA}}, 0);
    add_beat(64'h869F7745C13FD890, 64'hCCF29188E3CC3EDF, 0);
    add_beat(64'h8000000000000000, 64'h0000000000000001, 0);
    add_beat(64'h0000000000000001, 64'h8000000000000000, 0);
    for (int i = 0; i < 8; i++) add_beat(64'h1 << (8*i + i), 64'h1 << (63 - 9*i), 0);
    for (int ph = 0; ph < 4; ph++) begin
      idle = (ph == 1) ? 83 : (ph == 3) ? 11 : 0;
      for (int i = 0; i < 350; i++)
        add_beat({$urandom, $urandom}, {$urandom, $urandom}, idle);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (license_q.size() != 0 || start) @(posedge clk_i);
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (UnwrapLatency + 4) @(posedge clk_i);
    if (mismatches == 0) $display("license_key_unwrap_core test passed");
    else $display("license_key_unwrap_core test failed");
    $finish;
  end

  initial begin
    #400000;
    $display("license_key_unwrap_core test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/lku_pkg.sv
rtl/core/lku_aes_stage.sv
rtl/core/lku_mix_stage.sv
rtl/core/license_key_unwrap_core.sv
rtl/core/lku_checker.sv
verif/tb.sv
